// ===== design/strongly_connected_components_core_macros.svh =====
// assertion macros for the strongly connected components core
// used by strongly_connected_components_core.sv; needs clk and rst_n in scope
`ifndef STRONGLY_CONNECTED_COMPONENTS_CORE_MACROS_SVH
`define STRONGLY_CONNECTED_COMPONENTS_CORE_MACROS_SVH
`ifndef SYNTH
`define SCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCC_ASSERT(lbl, prop, msg)
`define SCC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/scc_pkg.sv =====
// types and constants for the strongly connected components core
// no dependencies
package scc_pkg;

  localparam int NODE_W = 6;
  localparam int CFG_W  = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] edge_from;
    logic [NODE_W-1:0] edge_to;
  } scc_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic [NODE_W-1:0] component_index;
    logic              last_in_component;
    logic              last_of_run;
    logic              edges_dropped;
  } scc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_F_ROOT, ST_F_RD, ST_F_CHK, ST_F_POP,
    ST_R_FIN, ST_R_FWAIT, ST_R_RD, ST_R_CHK, ST_R_DEC, ST_R_POP, ST_DONE
  } state_t;

  typedef struct packed {
    logic append;
    logic start_run;
    logic f_root;
    logic f_rd;
    logic f_chk;
    logic f_finish;
    logic pop_rd;
    logic load_top;
    logic r_init;
    logic fin_rd;
    logic r_start;
    logic r_rd;
    logic r_chk;
    logic r_take;
    logic comp_end;
    logic run_end;
  } scc_cmd_t;

  typedef struct packed {
    logic root_done;
    logic root_vis;
    logic cur_end;
    logic sp_zero;
    logic fin_zero;
    logic start_vis;
    logic j_end;
    logic found;
  } scc_stat_t;

endpackage

// ===== design/scc_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module scc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                   wdata,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                   rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/scc_ctrl.sv =====
// controller state machine for the strongly connected components core
// depends on scc_pkg
module scc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               kind,
  input  scc_pkg::scc_stat_t stat,
  output scc_pkg::scc_cmd_t  cmd,
  output logic               busy
);
  scc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      scc_pkg::ST_IDLE: begin
        if (start) begin
          if (kind) begin
            cmd.start_run = 1'b1;
            state_nxt     = scc_pkg::ST_F_ROOT;
          end else begin
            cmd.append = 1'b1;
          end
        end
      end
      scc_pkg::ST_F_ROOT: begin
        if (stat.root_done) begin
          cmd.r_init = 1'b1;
          state_nxt  = scc_pkg::ST_R_FIN;
        end else begin
          cmd.f_root = 1'b1;
          if (!stat.root_vis) state_nxt = scc_pkg::ST_F_RD;
        end
      end
      scc_pkg::ST_F_RD: begin
        if (stat.cur_end) begin
          cmd.f_finish = 1'b1;
          if (stat.sp_zero) begin
            state_nxt = scc_pkg::ST_F_ROOT;
          end else begin
            cmd.pop_rd = 1'b1;
            state_nxt  = scc_pkg::ST_F_POP;
          end
        end else begin
          cmd.f_rd  = 1'b1;
          state_nxt = scc_pkg::ST_F_CHK;
        end
      end
      scc_pkg::ST_F_CHK: begin
        cmd.f_chk = 1'b1;
        state_nxt = scc_pkg::ST_F_RD;
      end
      scc_pkg::ST_F_POP: begin
        cmd.load_top = 1'b1;
        state_nxt    = scc_pkg::ST_F_RD;
      end
      scc_pkg::ST_R_FIN: begin
        if (stat.fin_zero) begin
          state_nxt = scc_pkg::ST_DONE;
        end else begin
          cmd.fin_rd = 1'b1;
          state_nxt  = scc_pkg::ST_R_FWAIT;
        end
      end
      scc_pkg::ST_R_FWAIT: begin
        if (stat.start_vis) begin
          state_nxt = scc_pkg::ST_R_FIN;
        end else begin
          cmd.r_start = 1'b1;
          state_nxt   = scc_pkg::ST_R_RD;
        end
      end
      scc_pkg::ST_R_RD: begin
        if (stat.j_end) begin
          state_nxt = scc_pkg::ST_R_DEC;
        end else begin
          cmd.r_rd  = 1'b1;
          state_nxt = scc_pkg::ST_R_CHK;
        end
      end
      scc_pkg::ST_R_CHK: begin
        cmd.r_chk = 1'b1;
        state_nxt = scc_pkg::ST_R_RD;
      end
      scc_pkg::ST_R_DEC: begin
        if (stat.found) begin
          cmd.r_take = 1'b1;
          state_nxt  = scc_pkg::ST_R_RD;
        end else if (stat.sp_zero) begin
          cmd.comp_end = 1'b1;
          state_nxt    = scc_pkg::ST_R_FIN;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = scc_pkg::ST_R_POP;
        end
      end
      scc_pkg::ST_R_POP: begin
        cmd.load_top = 1'b1;
        state_nxt    = scc_pkg::ST_R_RD;
      end
      scc_pkg::ST_DONE: begin
        cmd.run_end = 1'b1;
        state_nxt   = scc_pkg::ST_IDLE;
      end
      default: state_nxt = scc_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_r != scc_pkg::ST_IDLE);
endmodule

// ===== design/scc_dp.sv =====
// datapath: edge store, search stack, finish order, visited marks and output
// depends on scc_pkg and scc_ram
module scc_dp #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scc_pkg::scc_cmd_t             cmd,
  input  scc_pkg::scc_in_t              item,
  input  logic                          cfg_we,
  input  logic [scc_pkg::CFG_W-1:0]     cfg_wdata,
  output scc_pkg::scc_stat_t            stat,
  output logic                          out_valid,
  output scc_pkg::scc_out_t             out_item
);
  localparam int NW   = scc_pkg::NODE_W;
  localparam int CW   = scc_pkg::CFG_W;
  localparam int NAW  = $clog2(MAX_NODES);
  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int KEYW = NW + EAW;
  localparam int KW   = KEYW + 1;
  localparam int SW   = NW + KW;

  logic [CW-1:0]        cfg_r, n_r, i_r, fin_r, emit_r;
  logic [NAW-1:0]       sp_r, comp_r;
  logic [NW-1:0]        top_r, pend_node_r;
  logic [NAW-1:0]       pend_comp_r;
  logic                 pend_vld_r;
  logic [KW-1:0]        cur_r;
  logic [ECW-1:0]       j_r, total_r;
  logic [KEYW-1:0]      best_r;
  logic                 best_vld_r, drop_r;
  logic [MAX_NODES-1:0] visited_r;
  logic                 out_valid_r;
  scc_pkg::scc_out_t    out_r;

  logic [CW-1:0]  n_act;
  logic [2*NW-1:0] edge_rdata;
  logic [NW-1:0]  e_src, e_tgt, fin_rdata, best_src, emit_node;
  logic [SW-1:0]  stk_rdata, stk_wdata;
  logic [KW-1:0]  cur_inc;
  logic [KEYW-1:0] key;
  logic           fwd_match, push_f, push_r, push, emit_en, edge_ok, rev_better;

  always_comb begin
    if (cfg_r == '0) n_act = CW'(1);
    else if (cfg_r > CW'(MAX_NODES)) n_act = CW'(MAX_NODES);
    else n_act = cfg_r;
  end

  assign e_src    = edge_rdata[2*NW-1:NW];
  assign e_tgt    = edge_rdata[NW-1:0];
  assign best_src = best_r[KEYW-1 -: NW];
  assign key      = {e_src, EAW'(j_r - ECW'(1))};

  assign fwd_match = (e_src == top_r) && (CW'(e_tgt) < n_r) && (CW'(e_src) < n_r);
  assign push_f    = cmd.f_chk && fwd_match && !visited_r[e_tgt[NAW-1:0]];
  assign push_r    = cmd.r_take && !visited_r[best_src[NAW-1:0]];
  assign push      = push_f || push_r;
  assign cur_inc   = cmd.r_take ? (KW'(best_r) + KW'(1)) : (cur_r + KW'(1));
  assign stk_wdata = {top_r, cur_inc};
  assign rev_better = (e_tgt == top_r) && (CW'(e_src) < n_r) && (KW'(key) >= cur_r) &&
                      (!best_vld_r || (key < best_r));
  assign emit_en   = cmd.r_start || push_r;
  assign emit_node = cmd.r_start ? fin_rdata : best_src;
  assign edge_ok   = (CW'(item.edge_from) < n_act) && (CW'(item.edge_to) < n_act) &&
                     (total_r < ECW'(MAX_EDGES));

  scc_ram #(.W(2*NW), .D(MAX_EDGES)) u_edges (
    .clk   (clk),
    .we    (cmd.append && edge_ok),
    .waddr (total_r[EAW-1:0]),
    .wdata ({item.edge_from, item.edge_to}),
    .raddr (cmd.f_rd ? cur_r[EAW-1:0] : j_r[EAW-1:0]),
    .rdata (edge_rdata)
  );

  scc_ram #(.W(SW), .D(MAX_NODES)) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (sp_r),
    .wdata (stk_wdata),
    .raddr (sp_r - NAW'(1)),
    .rdata (stk_rdata)
  );

  scc_ram #(.W(NW), .D(MAX_NODES)) u_finish (
    .clk   (clk),
    .we    (cmd.f_finish),
    .waddr (fin_r[NAW-1:0]),
    .wdata (top_r),
    .raddr (NAW'(fin_r - CW'(1))),
    .rdata (fin_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= scc_pkg::CFG_RESET;
      n_r         <= '0;
      i_r         <= '0;
      fin_r       <= '0;
      emit_r      <= '0;
      sp_r        <= '0;
      comp_r      <= '0;
      top_r       <= '0;
      cur_r       <= '0;
      j_r         <= '0;
      total_r     <= '0;
      best_r      <= '0;
      best_vld_r  <= 1'b0;
      drop_r      <= 1'b0;
      visited_r   <= '0;
      pend_vld_r  <= 1'b0;
      pend_node_r <= '0;
      pend_comp_r <= '0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      out_valid_r <= (emit_en && pend_vld_r) || cmd.comp_end;
      if (cfg_we) cfg_r <= cfg_wdata;
      if (cmd.append) begin
        if (edge_ok) total_r <= total_r + ECW'(1);
        else drop_r <= 1'b1;
      end
      if (cmd.start_run) begin
        n_r       <= n_act;
        visited_r <= '0;
        i_r       <= '0;
        fin_r     <= '0;
        sp_r      <= '0;
      end
      if (cmd.f_root) begin
        i_r <= i_r + CW'(1);
        if (!visited_r[i_r[NAW-1:0]]) begin
          visited_r[i_r[NAW-1:0]] <= 1'b1;
          top_r <= i_r[NW-1:0];
          cur_r <= '0;
        end
      end
      if (cmd.f_finish) fin_r <= fin_r + CW'(1);
      if (cmd.pop_rd) sp_r <= sp_r - NAW'(1);
      if (cmd.load_top) begin
        top_r      <= stk_rdata[SW-1:KW];
        cur_r      <= stk_rdata[KW-1:0];
        j_r        <= '0;
        best_vld_r <= 1'b0;
      end
      if (cmd.f_chk) begin
        if (push_f) begin
          sp_r <= sp_r + NAW'(1);
          visited_r[e_tgt[NAW-1:0]] <= 1'b1;
          top_r <= e_tgt;
          cur_r <= '0;
        end else begin
          cur_r <= cur_r + KW'(1);
        end
      end
      if (cmd.r_init) begin
        visited_r  <= '0;
        comp_r     <= '0;
        emit_r     <= '0;
        pend_vld_r <= 1'b0;
      end
      if (cmd.fin_rd) fin_r <= fin_r - CW'(1);
      if (cmd.r_start) begin
        visited_r[fin_rdata[NAW-1:0]] <= 1'b1;
        top_r      <= fin_rdata;
        cur_r      <= '0;
        j_r        <= '0;
        best_vld_r <= 1'b0;
      end
      if (cmd.r_rd) j_r <= j_r + ECW'(1);
      if (cmd.r_chk && rev_better) begin
        best_r     <= key;
        best_vld_r <= 1'b1;
      end
      if (cmd.r_take) begin
        j_r        <= '0;
        best_vld_r <= 1'b0;
        if (push_r) begin
          sp_r <= sp_r + NAW'(1);
          visited_r[best_src[NAW-1:0]] <= 1'b1;
          top_r <= best_src;
          cur_r <= '0;
        end else begin
          cur_r <= cur_inc;
        end
      end
      if (emit_en) begin
        if (pend_vld_r) begin
          out_r <= '{node_id: pend_node_r, component_index: NW'(pend_comp_r),
                     last_in_component: 1'b0, last_of_run: 1'b0, edges_dropped: drop_r};
        end
        pend_vld_r  <= 1'b1;
        pend_node_r <= emit_node;
        pend_comp_r <= comp_r;
        emit_r      <= emit_r + CW'(1);
      end
      if (cmd.comp_end) begin
        out_r <= '{node_id: pend_node_r, component_index: NW'(pend_comp_r),
                   last_in_component: 1'b1, last_of_run: (emit_r == n_r),
                   edges_dropped: drop_r};
        pend_vld_r <= 1'b0;
        comp_r     <= comp_r + NAW'(1);
      end
      if (cmd.run_end) begin
        total_r <= '0;
        drop_r  <= 1'b0;
      end
    end
  end

  assign stat.root_done = (i_r == n_r);
  assign stat.root_vis  = visited_r[i_r[NAW-1:0]];
  assign stat.cur_end   = (cur_r == KW'(total_r));
  assign stat.sp_zero   = (sp_r == '0);
  assign stat.fin_zero  = (fin_r == '0);
  assign stat.start_vis = visited_r[fin_rdata[NAW-1:0]];
  assign stat.j_end     = (j_r == total_r);
  assign stat.found     = best_vld_r;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
endmodule

// ===== design/strongly_connected_components_core.sv =====
// Kosaraju strongly connected components core. An edge item (kind 0) is taken while
// idle and, if both nodes are in range and the store has room, stored in insertion
// order; busy stays low. A run item (kind 1) raises busy until all node_count results
// are out. Each edge visit takes a read and a check on the edge store read port: the
// forward pass scans the whole edge list once per node, and the reverse pass rescans
// the whole edge list for every reversed edge taken and once more per node. Results come
// one per strobe cycle on out_valid and cannot be held off. Depends on scc_pkg, scc_ctrl,
// scc_dp and the macros.
`include "strongly_connected_components_core_macros.svh"
module strongly_connected_components_core #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  scc_pkg::scc_in_t          in_item,
  output logic                      out_valid,
  output scc_pkg::scc_out_t         out_item,
  input  logic                      cfg_we,
  input  logic [scc_pkg::CFG_W-1:0] cfg_wdata
);
  scc_pkg::scc_cmd_t  cmd;
  scc_pkg::scc_stat_t stat;
  logic               out_last_run;

  scc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_item.kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  scc_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .item      (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_last_run = out_valid && out_item.last_of_run;

  `SCC_ASSERT(a_out_in_run, out_valid |-> busy, "result outside a run")
  `SCC_ASSERT(a_last_run, out_last_run |-> out_item.last_in_component, "bad run end")
  `SCC_ASSERT(a_run_busy, (start && !busy && in_item.kind) |=> busy, "run item did not start")
  `SCC_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !busy && !out_valid, "busy after reset")
endmodule

// ===== tb/scc_checker.sv =====
// checker for the strongly connected components core: watches items and results,
// predicts the component listing of each run and compares field by field
// depends on scc_pkg
module scc_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  scc_pkg::scc_in_t  in_item,
  input  logic              out_valid,
  input  scc_pkg::scc_out_t out_item,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMAX = 64;
  localparam int EMAX = 256;
  localparam int NONE = 32'h7fffffff;

  logic [6:0]        node_cfg;
  logic [5:0]        esrc [EMAX];
  logic [5:0]        edst [EMAX];
  int                ecount;
  logic              dropped;
  scc_pkg::scc_out_t listing_q [$];

  assign pending = listing_q.size();

  function automatic int live_nodes();
    if (node_cfg == 0) return 1;
    if (node_cfg > NMAX) return NMAX;
    return int'(node_cfg);
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic int fwd_next(int u, int from, int n);
    for (int j = from; j < ecount; j++)
      if (esrc[j] == u && edst[j] < n && esrc[j] < n) return j;
    return NONE;
  endfunction

  function automatic int rev_next(int v, int from, int n);
    int best;
    int k;
    best = NONE;
    for (int j = 0; j < ecount; j++) begin
      if (edst[j] != v || esrc[j] >= n) continue;
      k = int'(esrc[j]) * EMAX + j;
      if (k >= from && k < best) best = k;
    end
    return best;
  endfunction

  task automatic predict_components();
    int n, fin, sp, u, j, w, comp, first;
    bit seen [NMAX];
    int fo [NMAX];
    int snode [NMAX];
    int scur [NMAX];
    scc_pkg::scc_out_t r;
    n = live_nodes();
    fin = 0;
    comp = 0;
    foreach (seen[i]) seen[i] = 0;
    for (int i = 0; i < n; i++) begin
      if (seen[i]) continue;
      seen[i] = 1;
      snode[0] = i;
      scur[0] = 0;
      sp = 1;
      while (sp > 0) begin
        u = snode[sp-1];
        j = fwd_next(u, scur[sp-1], n);
        if (j == NONE) begin
          fo[fin] = u;
          fin++;
          sp--;
        end else begin
          w = int'(edst[j]);
          scur[sp-1] = j + 1;
          if (!seen[w]) begin
            seen[w] = 1;
            snode[sp] = w;
            scur[sp] = 0;
            sp++;
          end
        end
      end
    end
    foreach (seen[i]) seen[i] = 0;
    while (fin > 0) begin
      fin--;
      u = fo[fin];
      if (seen[u]) continue;
      seen[u] = 1;
      snode[0] = u;
      scur[0] = 0;
      sp = 1;
      r = '0;
      r.node_id = 6'(u);
      r.component_index = 6'(comp);
      r.edges_dropped = dropped;
      listing_q.insert(listing_q.size(), r);
      while (sp > 0) begin
        j = rev_next(snode[sp-1], scur[sp-1], n);
        if (j == NONE) begin
          sp--;
        end else begin
          w = j / EMAX;
          scur[sp-1] = j + 1;
          if (!seen[w]) begin
            seen[w] = 1;
            snode[sp] = w;
            scur[sp] = 0;
            sp++;
            r.node_id = 6'(w);
            listing_q.insert(listing_q.size(), r);
          end
        end
      end
      listing_q[listing_q.size()-1].last_in_component = 1'b1;
      comp++;
    end
    listing_q[listing_q.size()-1].last_of_run = 1'b1;
    ecount = 0;
    dropped = 0;
  endtask

  always @(posedge clk) begin
    scc_pkg::scc_out_t e;
    int n;
    if (!rst_n) begin
      node_cfg <= scc_pkg::CFG_RESET;
      ecount = 0;
      dropped = 0;
      fail_count = 0;
      listing_q.delete();
    end else begin
      if (out_valid) begin
        if (listing_q.size() == 0) begin
          report("unexpected result node", int'(out_item.node_id), -1);
        end else begin
          e = listing_q.pop_front();
          if (out_item.node_id != e.node_id)
            report("node_id", int'(out_item.node_id), int'(e.node_id));
          if (out_item.component_index != e.component_index)
            report("component_index", int'(out_item.component_index),
                   int'(e.component_index));
          if (out_item.last_in_component != e.last_in_component)
            report("last_in_component", int'(out_item.last_in_component),
                   int'(e.last_in_component));
          if (out_item.last_of_run != e.last_of_run)
            report("last_of_run", int'(out_item.last_of_run), int'(e.last_of_run));
          if (out_item.edges_dropped != e.edges_dropped)
            report("edges_dropped", int'(out_item.edges_dropped), int'(e.edges_dropped));
        end
      end
      if (start && !busy) begin
        n = live_nodes();
        if (in_item.kind) begin
          predict_components();
        end else if (in_item.edge_from >= n || in_item.edge_to >= n || ecount >= EMAX) begin
          dropped = 1;
        end else begin
          esrc[ecount] = in_item.edge_from;
          edst[ecount] = in_item.edge_to;
          ecount++;
        end
      end
      if (cfg_we) node_cfg <= cfg_wdata;
    end
  end
endmodule

// ===== tb/strongly_connected_components_core_tb.sv =====
// testbench top for the strongly connected components core: edge loads and runs
// with random gaps and node counts, verdict from the scc_checker failure count
// depends on scc_pkg, scc_checker and the core
module strongly_connected_components_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT = 1000000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  scc_pkg::scc_in_t  in_item = '0;
  logic              out_valid;
  scc_pkg::scc_out_t out_item;
  logic              cfg_we = 1'b0;
  logic [6:0]        cfg_wdata = '0;
  int                fail_count;
  int                pending;
  int                idle_cycles = 0;
  int                items_sent = 0;
  bit                quiet_tail = 0;
  int                cur_nodes = 64;

  always #5 clk = ~clk;

  strongly_connected_components_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  scc_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(input logic kind, input int a, input int b);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    start <= 1'b1;
    in_item.kind <= kind;
    in_item.edge_from <= 6'(a);
    in_item.edge_to <= 6'(b);
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_nodes(input int v);
    cfg_we <= 1'b1;
    cfg_wdata <= 7'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_nodes = (v == 0) ? 1 : (v > 64 ? 64 : v);
  endtask

  task automatic random_graph(input int edges);
    int m;
    for (int k = 0; k < edges; k++) begin
      m = cur_nodes;
      if ($urandom_range(0, 15) == 0) send_item(1'b0, $urandom_range(0, 63), $urandom_range(0, 63));
      else send_item(1'b0, $urandom_range(0, m - 1), $urandom_range(0, m - 1));
    end
    send_item(1'b1, $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  initial begin
    int nodes_pick [6];
    nodes_pick = '{1, 2, 5, 8, 16, 64};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_item(1'b1, 63, 63);
    drain();
    set_nodes(4);
    send_item(1'b0, 0, 1);
    send_item(1'b0, 1, 0);
    send_item(1'b0, 1, 2);
    send_item(1'b0, 2, 2);
    send_item(1'b0, 2, 3);
    send_item(1'b0, 2, 3);
    send_item(1'b0, 3, 63);
    send_item(1'b0, 63, 0);
    send_item(1'b1, 0, 0);
    drain();
    set_nodes(8);
    send_item(1'b0, 7, 6);
    send_item(1'b0, 6, 5);
    send_item(1'b0, 5, 7);
    send_item(1'b0, 0, 7);
    drain();
    set_nodes(6);
    send_item(1'b1, 0, 0);
    drain();
    set_nodes(0);
    send_item(1'b0, 0, 0);
    send_item(1'b1, 0, 0);
    drain();
    set_nodes(127);
    for (int k = 0; k < 260; k++) send_item(1'b0, k % 64, (k * 7 + 3) % 64);
    send_item(1'b1, 0, 0);
    drain();
    while (items_sent < 305) begin
      set_nodes(nodes_pick[$urandom_range(0, 5)]);
      if ($urandom_range(0, 9) == 0) set_nodes($urandom_range(0, 127));
      if (items_sent > 285) quiet_tail = 1;
      random_graph($urandom_range(0, (cur_nodes > 8) ? 24 : 10));
      drain();
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
